FILE: sv/v3norm_pkg.sv
// types and constants shared by the vector normalize core
package v3norm_pkg;

  localparam int InWidth  = 16;
  localparam int FracBits = 14;
  localparam int OutWidth = 16;
  localparam int Lanes    = 3;
  localparam int SqW      = 2 * InWidth - 1;
  localparam int SumW     = 2 * InWidth;
  localparam int ErrW     = SumW + 2 * FracBits + 6;
  localparam int ProdW    = SumW + FracBits + 3;
  localparam int KW       = FracBits + 1;

  typedef struct packed {
    logic signed [InWidth-1:0] comp_x;
    logic signed [InWidth-1:0] comp_y;
    logic signed [InWidth-1:0] comp_z;
  } vec_beat_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] unit_x;
    logic signed [OutWidth-1:0] unit_y;
    logic signed [OutWidth-1:0] unit_z;
    logic                       zero_input;
  } unit_beat_t;

  typedef struct packed {
    logic [Lanes-1:0][ErrW-1:0] err;
    logic [SumW-1:0]            sum;
    logic [Lanes-1:0]           neg;
    logic                       zero;
  } job_t;

endpackage

FILE: sv/v3norm_front.sv
// front end: takes beats, squares components, forms the sum and initial error terms
module v3norm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  v3norm_pkg::vec_beat_t vec_i,
  input  logic                  full_i,
  output logic                  busy,
  output logic                  push_o,
  output v3norm_pkg::job_t      job_o
);
  import v3norm_pkg::*;

  logic                         stall;
  logic [Lanes-1:0][InWidth-1:0] comp;
  logic [Lanes-1:0][InWidth-1:0] mag;
  logic [Lanes-1:0][SqW-1:0]    sq;
  logic [Lanes-1:0]             neg;

  logic                         s1_vld_q;
  logic [Lanes-1:0][SqW-1:0]    sq_q;
  logic [Lanes-1:0]             neg_q;

  logic [SumW-1:0]              sum_d;
  job_t                         job_d;
  logic                         s2_vld_q;
  job_t                         job_q;

  assign comp[0] = vec_i.comp_x;
  assign comp[1] = vec_i.comp_y;
  assign comp[2] = vec_i.comp_z;

  for (genvar l = 0; l < Lanes; l++) begin : g_sq
    logic [2*InWidth-1:0] prod;
    assign neg[l]  = comp[l][InWidth-1];
    assign mag[l]  = neg[l] ? (~comp[l] + 1'b1) : comp[l];
    assign prod    = (2*InWidth)'(mag[l]) * (2*InWidth)'(mag[l]);
    assign sq[l]   = prod[SqW-1:0];
  end

  assign sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);

  always_comb begin
    job_d.sum  = sum_d;
    job_d.neg  = neg_q;
    job_d.zero = (sum_d == '0);
    for (int l = 0; l < Lanes; l++) begin
      job_d.err[l] = (ErrW'(sq_q[l]) << (2 * FracBits + 2)) - ErrW'(sum_d);
    end
  end

  assign stall  = s2_vld_q & full_i;
  assign busy   = stall;
  assign push_o = s2_vld_q & ~full_i;
  assign job_o  = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (!stall) begin
      s1_vld_q <= start;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      if (start) begin
        sq_q  <= sq;
        neg_q <= neg;
      end
      if (s1_vld_q) begin
        job_q <= job_d;
      end
    end
  end

endmodule

FILE: sv/v3norm_queue.sv
// short job queue between the front end and the iteration pipeline
module v3norm_queue #(
  parameter int QDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  v3norm_pkg::job_t job_i,
  output logic             full_o,
  output logic             pop_o,
  output v3norm_pkg::job_t head_o
);
  import v3norm_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign pop_o  = (cnt_q != '0);
  assign full_o = (cnt_q == CntW'(QDepth));
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_o) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("queue count above depth");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> cnt_q != '0)
    else $error("pushed beat not held in queue");

endmodule

FILE: sv/v3norm_back.sv
// back end: bit-per-stage search for the rounded unit magnitudes, then sign and output
module v3norm_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_i,
  input  v3norm_pkg::job_t       job_i,
  output logic                   done_o,
  output v3norm_pkg::unit_beat_t unit_o
);
  import v3norm_pkg::*;

  localparam int NStg = FracBits + 2;

  logic [NStg-1:0]              vld_q;
  logic [Lanes-1:0][ErrW-1:0]   err_q [NStg];
  logic [Lanes-1:0][ProdW-1:0]  pp_q  [NStg];
  logic [Lanes-1:0][KW-1:0]     k_q   [NStg];
  logic [SumW-1:0]              sum_q [NStg];
  logic [Lanes-1:0]             neg_q [NStg];
  logic [NStg-1:0]              zero_q;

  logic [Lanes-1:0][ErrW-1:0]   err_d [NStg-1];
  logic [Lanes-1:0][ProdW-1:0]  pp_d  [NStg-1];
  logic [Lanes-1:0][KW-1:0]     k_d   [NStg-1];

  logic [Lanes-1:0][OutWidth-1:0] val;
  unit_beat_t                   unit_d;
  unit_beat_t                   unit_q;
  logic                         done_q;

  // stage s decides bit FracBits-s of each magnitude
  for (genvar s = 0; s < NStg - 1; s++) begin : g_stg
    localparam int Bit = FracBits - s;
    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [ErrW-1:0] pext, sext, dec, trial;
      logic            take;
      assign pext  = {{(ErrW-ProdW){pp_q[s][l][ProdW-1]}}, pp_q[s][l]};
      assign sext  = {{(ErrW-SumW){1'b0}}, sum_q[s]};
      assign dec   = (pext << (Bit + 2)) + (sext << (2 * Bit + 2));
      assign trial = err_q[s][l] - dec;
      assign take  = ~trial[ErrW-1];
      assign err_d[s][l] = take ? trial : err_q[s][l];
      assign pp_d[s][l]  = take ? pp_q[s][l] + (ProdW'(sum_q[s]) << (Bit + 1)) : pp_q[s][l];
      assign k_d[s][l]   = k_q[s][l] | (KW'(take) << Bit);
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_out
    logic [OutWidth-1:0] mag;
    assign mag    = OutWidth'(k_q[NStg-1][l]);
    assign val[l] = zero_q[NStg-1] ? '0 : (neg_q[NStg-1][l] ? ('0 - mag) : mag);
  end

  assign unit_d.unit_x     = val[0];
  assign unit_d.unit_y     = val[1];
  assign unit_d.unit_z     = val[2];
  assign unit_d.zero_input = zero_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[NStg-2:0], pop_i};
      done_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      err_q[0]  <= job_i.err;
      sum_q[0]  <= job_i.sum;
      neg_q[0]  <= job_i.neg;
      zero_q[0] <= job_i.zero;
      k_q[0]    <= '0;
      for (int l = 0; l < Lanes; l++) begin
        pp_q[0][l] <= {ProdW{1'b0}} - ProdW'(job_i.sum);
      end
    end
    for (int s = 0; s < NStg - 1; s++) begin
      if (vld_q[s]) begin
        err_q[s+1]  <= err_d[s];
        pp_q[s+1]   <= pp_d[s];
        k_q[s+1]    <= k_d[s];
        sum_q[s+1]  <= sum_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
    if (vld_q[NStg-1]) begin
      unit_q <= unit_d;
    end
  end

  assign done_o = done_q;
  assign unit_o = unit_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##(NStg) done_o)
    else $error("beat lost in iteration pipeline");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && unit_o.zero_input) |->
      (unit_o.unit_x == '0 && unit_o.unit_y == '0 && unit_o.unit_z == '0))
    else $error("zero vector gave nonzero components");

endmodule

FILE: sv/vector3_normalize_core.sv
// top level of the 3d vector normalize core
// an accepted start beat passes front s1, s2, the job queue, back end stages and done_q
// throughput: one beat per cycle; the iteration pipeline drains the queue every cycle
// busy rises only when the job queue is full, which the never-stalling back end prevents
// reset clears all valid bits and queue pointers; no result is pending after reset
module vector3_normalize_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  v3norm_pkg::vec_beat_t  vec_i,
  output logic                   busy,
  output logic                   done_o,
  output v3norm_pkg::unit_beat_t unit_o
);
  import v3norm_pkg::*;

  logic full;
  logic push;
  logic pop;
  job_t job_in;
  job_t job_head;

  v3norm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .vec_i  (vec_i),
    .full_i (full),
    .busy   (busy),
    .push_o (push),
    .job_o  (job_in)
  );

  v3norm_queue #(
    .QDepth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_o  (pop),
    .head_o (job_head)
  );

  v3norm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pop_i  (pop),
    .job_i  (job_head),
    .done_o (done_o),
    .unit_o (unit_o)
  );

endmodule
